### hdl/tabd_pkg.sv
// Shared constants, codes and transaction structs for the tilt angle LED driver.
package tabd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int ANGLE_W = 16;
  localparam int OFS_W = 9;
  // divider operand widths: numerator is a sample difference times 90, at least a full angle
  localparam int DIV_N = (SAMPLE_BITS + 7 > ANGLE_W + 1) ? SAMPLE_BITS + 7 : ANGLE_W + 1;
  localparam int DIV_D = SAMPLE_BITS;
  localparam int CNT_W = $clog2(DIV_N + 1);

  // item kinds
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_ENABLE = 2'd1;
  localparam logic [1:0] FUNC_MODE   = 2'd2;

  // configuration register indexes
  localparam logic CFG_Y_ZERO = 1'b0;
  localparam logic CFG_Y_FULL = 1'b1;

  localparam logic [SAMPLE_BITS-1:0] Y_ZERO_RST = SAMPLE_BITS'(504);
  localparam logic [SAMPLE_BITS-1:0] Y_FULL_RST = SAMPLE_BITS'(606);

  localparam logic [DIV_D-1:0] DIGIT_BASE = DIV_D'(10);

  // x mode quadrant windows, inclusive bounds
  localparam logic [15:0] X_511 = 16'd511;
  localparam logic [15:0] X_618 = 16'd618;
  localparam logic [15:0] X_520 = 16'd520;
  localparam logic [15:0] X_411 = 16'd411;
  localparam logic [15:0] Z_522 = 16'd522;
  localparam logic [15:0] Z_620 = 16'd620;
  localparam logic [15:0] Z_418 = 16'd418;
  localparam logic [15:0] Z_518 = 16'd518;

  localparam logic [DIV_D-1:0] W0_DEN = DIV_D'(107);
  localparam logic [DIV_D-1:0] W1_DEN = DIV_D'(98);
  localparam logic [DIV_D-1:0] W2_DEN = DIV_D'(109);
  localparam logic [DIV_D-1:0] W3_DEN = DIV_D'(100);

  localparam logic [OFS_W-1:0] W0_OFS = OFS_W'(0);
  localparam logic [OFS_W-1:0] W1_OFS = OFS_W'(90);
  localparam logic [OFS_W-1:0] W2_OFS = OFS_W'(180);
  localparam logic [OFS_W-1:0] W3_OFS = OFS_W'(270);

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DIV_D-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_N-1:0] quot;
    logic [DIV_D-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic                   use_div;
    logic                   hold_last;
    logic [SAMPLE_BITS-1:0] num;
    logic [DIV_D-1:0]       den;
    logic [OFS_W-1:0]       offset;
  } map_t;

endpackage

### hdl/tabd_div.sv
// Shared restoring divider, one quotient bit per cycle.
module tabd_div (
  input  logic                clk,
  input  logic                rst,
  input  tabd_pkg::div_req_t  req,
  output tabd_pkg::div_rsp_t  rsp
);

  logic                           busy;
  logic                           done;
  logic [tabd_pkg::CNT_W-1:0]     cnt;
  logic [tabd_pkg::DIV_N-1:0]     quot;
  logic [tabd_pkg::DIV_D-1:0]     rem;
  logic [tabd_pkg::DIV_D-1:0]     den;
  logic [tabd_pkg::DIV_D:0]       rem_sh;
  logic [tabd_pkg::DIV_D:0]       rem_sub;
  logic                           fits;

  always_comb begin
    rem_sh  = {rem, quot[tabd_pkg::DIV_N-1]};
    rem_sub = rem_sh - {1'b0, den};
    fits    = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= tabd_pkg::CNT_W'(tabd_pkg::DIV_N);
        quot <= req.dividend;
        rem  <= '0;
        den  <= req.divisor;
      end else if (busy) begin
        quot <= {quot[tabd_pkg::DIV_N-2:0], fits};
        // partial remainder stays below the divisor, so the top bit drops
        rem  <= fits ? rem_sub[tabd_pkg::DIV_D-1:0] : rem_sh[tabd_pkg::DIV_D-1:0];
        cnt  <= cnt - tabd_pkg::CNT_W'(1);
        if (cnt == tabd_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

### hdl/tabd_map.sv
// Window select and linear map setup: numerator, divisor and offset for one sample.
module tabd_map (
  input  logic [tabd_pkg::SAMPLE_BITS-1:0] x_sample,
  input  logic [tabd_pkg::SAMPLE_BITS-1:0] z_sample,
  input  logic [tabd_pkg::SAMPLE_BITS-1:0] y_sample,
  input  logic [tabd_pkg::SAMPLE_BITS-1:0] y_zero,
  input  logic [tabd_pkg::SAMPLE_BITS-1:0] y_full,
  input  logic                             y_mode,
  output tabd_pkg::map_t                   map
);

  logic [15:0]                      xw;
  logic [15:0]                      zw;
  logic [tabd_pkg::SAMPLE_BITS-1:0] y_dist;
  logic [tabd_pkg::SAMPLE_BITS-1:0] span;
  logic                             win0, win1, win2, win3;

  always_comb begin
    xw = 16'(x_sample);
    zw = 16'(z_sample);
    y_dist = (y_sample >= y_zero) ? y_sample - y_zero : y_zero - y_sample;
    span   = (y_full >= y_zero) ? y_full - y_zero : y_zero - y_full;

    win0 = (xw >= tabd_pkg::X_511) && (xw <= tabd_pkg::X_618) &&
           (zw >= tabd_pkg::Z_522) && (zw <= tabd_pkg::Z_620);
    win1 = (xw >= tabd_pkg::X_520) && (xw <= tabd_pkg::X_618) &&
           (zw >= tabd_pkg::Z_418) && (zw <= tabd_pkg::Z_522);
    win2 = (xw >= tabd_pkg::X_411) && (xw <= tabd_pkg::X_520) &&
           (zw >= tabd_pkg::Z_418) && (zw <= tabd_pkg::Z_518);
    win3 = (xw >= tabd_pkg::X_411) && (xw <= tabd_pkg::X_511) &&
           (zw >= tabd_pkg::Z_518) && (zw <= tabd_pkg::Z_620);

    map = '0;
    if (y_mode) begin
      // zero span leaves everything clear: angle 0
      if (span != '0) begin
        map.use_div = 1'b1;
        map.num     = y_dist;
        map.den     = tabd_pkg::DIV_D'(span);
      end
    end else begin
      priority if (win0) begin
        map.use_div = 1'b1;
        map.num     = tabd_pkg::SAMPLE_BITS'(xw - tabd_pkg::X_511);
        map.den     = tabd_pkg::W0_DEN;
        map.offset  = tabd_pkg::W0_OFS;
      end else if (win1) begin
        map.use_div = 1'b1;
        map.num     = tabd_pkg::SAMPLE_BITS'(tabd_pkg::X_618 - xw);
        map.den     = tabd_pkg::W1_DEN;
        map.offset  = tabd_pkg::W1_OFS;
      end else if (win2) begin
        map.use_div = 1'b1;
        map.num     = tabd_pkg::SAMPLE_BITS'(tabd_pkg::X_520 - xw);
        map.den     = tabd_pkg::W2_DEN;
        map.offset  = tabd_pkg::W2_OFS;
      end else if (win3) begin
        map.use_div = 1'b1;
        map.num     = tabd_pkg::SAMPLE_BITS'(xw - tabd_pkg::X_411);
        map.den     = tabd_pkg::W3_DEN;
        map.offset  = tabd_pkg::W3_OFS;
      end else begin
        map.hold_last = 1'b1;
      end
    end
  end

endmodule

### hdl/tilt_angle_to_bcd_leds_top.sv
// Top level: item sequencer, flags, LED patterns and output register around the shared divider.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready   | func, x_sample, z_sample, y_sample
//  out     | output    | out_valid / out_ready | angle, angle_valid, link_enabled, y_mode,
//          |           |                       | ones_leds, tens_leds, hundreds_leds
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A button transaction or a disabled sample goes from accept through the setup and output states.
// An enabled sample takes one divider pass for the angle, then two passes by ten for the digits,
// all on the one shared divider; a sample that keeps the last x angle or meets a zero span skips
// the angle pass.
// in_ready is high only while idle; a finished result sits in the output register, so the
// next transaction is taken while it waits, and only the hand-off waits on out_ready.
// Reset is synchronous; configuration writes are always accepted.
module tilt_angle_to_bcd_leds_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       func,
  input  logic [tabd_pkg::SAMPLE_BITS-1:0] x_sample,
  input  logic [tabd_pkg::SAMPLE_BITS-1:0] z_sample,
  input  logic [tabd_pkg::SAMPLE_BITS-1:0] y_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      angle,
  output logic                             angle_valid,
  output logic                             link_enabled,
  output logic                             y_mode,
  output logic [4:0]                       ones_leds,
  output logic [3:0]                       tens_leds,
  output logic [3:0]                       hundreds_leds,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [tabd_pkg::SAMPLE_BITS-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ANGLE,
    ST_ONES,
    ST_TENS,
    ST_OUT
  } state_t;

  state_t                            state;
  logic [1:0]                        func_q;
  logic [tabd_pkg::SAMPLE_BITS-1:0]  x_q, z_q, y_q;
  logic [tabd_pkg::SAMPLE_BITS-1:0]  y_zero, y_full;
  logic                              enable_flag;
  logic                              mode_flag;
  logic [tabd_pkg::ANGLE_W-1:0]      last_x_angle;
  logic [4:0]                        ones_pattern;
  logic [3:0]                        tens_pattern;
  logic [3:0]                        hundreds_pattern;
  logic [tabd_pkg::ANGLE_W-1:0]      angle_r;
  logic                              valid_r;
  logic [tabd_pkg::OFS_W-1:0]        ofs_r;
  logic [3:0]                        ones_dig;

  tabd_pkg::map_t                    map;
  tabd_pkg::div_req_t                div_req;
  tabd_pkg::div_rsp_t                div_rsp;
  logic [tabd_pkg::DIV_N-1:0]        num_ext;
  logic [tabd_pkg::DIV_N-1:0]        num_x90;
  logic [tabd_pkg::ANGLE_W-1:0]      setup_angle;
  logic [tabd_pkg::ANGLE_W-1:0]      div_angle;
  logic                              sample_go;

  tabd_map u_map (
    .x_sample (x_q),
    .z_sample (z_q),
    .y_sample (y_q),
    .y_zero   (y_zero),
    .y_full   (y_full),
    .y_mode   (mode_flag),
    .map      (map)
  );

  tabd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    num_ext     = tabd_pkg::DIV_N'(map.num);
    // times 90 as shifts and adds
    num_x90     = (num_ext << 6) + (num_ext << 4) + (num_ext << 3) + (num_ext << 1);
    setup_angle = map.hold_last ? last_x_angle : '0;
    div_angle   = tabd_pkg::ANGLE_W'(ofs_r) + div_rsp.quot[tabd_pkg::ANGLE_W-1:0];
    sample_go   = (func_q == tabd_pkg::FUNC_SAMPLE) && enable_flag;

    div_req = '0;
    unique case (state)
      ST_SETUP: begin
        div_req.start = sample_go;
        if (map.use_div) begin
          div_req.dividend = num_x90;
          div_req.divisor  = map.den;
        end else begin
          div_req.dividend = tabd_pkg::DIV_N'(setup_angle);
          div_req.divisor  = tabd_pkg::DIGIT_BASE;
        end
      end
      ST_ANGLE: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = tabd_pkg::DIV_N'(div_angle);
        div_req.divisor  = tabd_pkg::DIGIT_BASE;
      end
      ST_ONES: begin
        // angle / 100 is (angle / 10) / 10
        div_req.start    = div_rsp.done;
        div_req.dividend = div_rsp.quot;
        div_req.divisor  = tabd_pkg::DIGIT_BASE;
      end
      ST_IDLE, ST_TENS, ST_OUT: begin
        div_req = '0;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      enable_flag      <= 1'b0;
      mode_flag        <= 1'b0;
      last_x_angle     <= '0;
      ones_pattern     <= '0;
      tens_pattern     <= '0;
      hundreds_pattern <= '0;
      y_zero           <= tabd_pkg::Y_ZERO_RST;
      y_full           <= tabd_pkg::Y_FULL_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          tabd_pkg::CFG_Y_ZERO: y_zero <= cfg_data;
          tabd_pkg::CFG_Y_FULL: y_full <= cfg_data;
          default:              y_zero <= y_zero;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            x_q    <= x_sample;
            z_q    <= z_sample;
            y_q    <= y_sample;
            state  <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          valid_r <= 1'b0;
          angle_r <= '0;
          state   <= ST_OUT;
          unique case (func_q)
            tabd_pkg::FUNC_ENABLE: enable_flag <= ~enable_flag;
            tabd_pkg::FUNC_MODE:   mode_flag   <= ~mode_flag;
            tabd_pkg::FUNC_SAMPLE: begin
              if (enable_flag) begin
                valid_r <= 1'b1;
                if (map.use_div) begin
                  ofs_r <= map.offset;
                  state <= ST_ANGLE;
                end else begin
                  angle_r <= setup_angle;
                  state   <= ST_ONES;
                end
              end else begin
                ones_pattern <= '0;
                tens_pattern <= '0;
              end
            end
            default: valid_r <= 1'b0;
          endcase
        end
        ST_ANGLE: begin
          if (div_rsp.done) begin
            angle_r <= div_angle;
            if (!mode_flag) begin
              last_x_angle <= div_angle;
            end
            state <= ST_ONES;
          end
        end
        ST_ONES: begin
          if (div_rsp.done) begin
            ones_dig <= div_rsp.rem[3:0];
            state    <= ST_TENS;
          end
        end
        ST_TENS: begin
          if (div_rsp.done) begin
            ones_pattern <= {ones_dig[0], ones_dig[1], ones_dig[2], ones_dig[3], 1'b0};
            tens_pattern <= div_rsp.rem[3:0];
            // hundreds above 3 leave the pattern alone
            if (div_rsp.quot <= tabd_pkg::DIV_N'(3)) begin
              hundreds_pattern <= {div_rsp.quot[1:0], 2'b00};
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            angle         <= angle_r;
            angle_valid   <= valid_r;
            link_enabled  <= enable_flag;
            y_mode        <= mode_flag;
            ones_leds     <= ones_pattern;
            tens_leds     <= tens_pattern;
            hundreds_leds <= hundreds_pattern;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### test/tilt_angle_to_bcd_leds_top_test.sv
// Self-checking testbench for the tilt angle to BCD LED driver: directed and random items.
`timescale 1ns / 1ps

module tilt_angle_to_bcd_leds_top_test;

  // func code 3 carries no meaning; the block reports it like a button press
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_RESULT = 150;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [1:0] func;
    logic [9:0] x;
    logic [9:0] z;
    logic [9:0] y;
  } tilt_item_t;

  typedef struct {
    logic [15:0] angle;
    logic        valid;
    logic        enabled;
    logic        ymode;
    logic [4:0]  ones;
    logic [3:0]  tens;
    logic [3:0]  hund;
  } led_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = tabd_pkg::FUNC_SAMPLE;
  logic [tabd_pkg::SAMPLE_BITS-1:0] x_sample = '0;
  logic [tabd_pkg::SAMPLE_BITS-1:0] z_sample = '0;
  logic [tabd_pkg::SAMPLE_BITS-1:0] y_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] angle;
  logic angle_valid;
  logic link_enabled;
  logic y_mode;
  logic [4:0] ones_leds;
  logic [3:0] tens_leds;
  logic [3:0] hundreds_leds;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = tabd_pkg::CFG_Y_ZERO;
  logic [tabd_pkg::SAMPLE_BITS-1:0] cfg_data = '0;

  tilt_angle_to_bcd_leds_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .x_sample(x_sample), .z_sample(z_sample), .y_sample(y_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .angle(angle), .angle_valid(angle_valid), .link_enabled(link_enabled),
    .y_mode(y_mode), .ones_leds(ones_leds), .tens_leds(tens_leds),
    .hundreds_leds(hundreds_leds),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state, mirrors the block
  logic [9:0]  y_zero_cfg = 10'd504;
  logic [9:0]  y_full_cfg = 10'd606;
  logic        enable_q = 1'b0;
  logic        mode_q = 1'b0;
  logic [15:0] last_x_angle = '0;
  logic [4:0]  ones_pat = '0;
  logic [3:0]  tens_pat = '0;
  logic [3:0]  hund_pat = '0;

  tilt_item_t pending_items[$];
  led_frame_t expected_frames[$];
  tilt_item_t offered;
  int issued_count = 0;
  int checked_count = 0;
  int fail_count = 0;
  logic steady = 1'b0;
  logic gen_enabled = 1'b0;
  logic gen_ymode = 1'b0;

  function automatic logic [15:0] tilt_from_xz(int x, int z);
    if (x >= 511 && x <= 618 && z >= 522 && z <= 620)
      last_x_angle = 16'((x - 511) * 90 / 107);
    else if (x >= 520 && x <= 618 && z >= 418 && z <= 522)
      last_x_angle = 16'(90 + (618 - x) * 90 / 98);
    else if (x >= 411 && x <= 520 && z >= 418 && z <= 518)
      last_x_angle = 16'(180 + (520 - x) * 90 / 109);
    else if (x >= 411 && x <= 511 && z >= 518 && z <= 620)
      last_x_angle = 16'(270 + (x - 411) * 90 / 100);
    return last_x_angle;
  endfunction

  function automatic logic [15:0] tilt_from_y(int y);
    int zero_c;
    int full_c;
    int span;
    int y_off;
    zero_c = int'(y_zero_cfg);
    full_c = int'(y_full_cfg);
    span = (full_c >= zero_c) ? full_c - zero_c : zero_c - full_c;
    y_off = (y >= zero_c) ? y - zero_c : zero_c - y;
    if (span == 0) return 16'd0;
    return 16'(y_off * 90 / span);
  endfunction

  function automatic led_frame_t predict_frame(tilt_item_t it);
    led_frame_t f;
    logic [15:0] ang;
    int a;
    int d_ones;
    int d_tens;
    int d_hund;
    ang = '0;
    f.valid = 1'b0;
    if (it.func == tabd_pkg::FUNC_ENABLE) begin
      enable_q = !enable_q;
    end else if (it.func == tabd_pkg::FUNC_MODE) begin
      mode_q = !mode_q;
    end else if (it.func == tabd_pkg::FUNC_SAMPLE) begin
      if (enable_q) begin
        ang = mode_q ? tilt_from_y(int'(it.y)) : tilt_from_xz(int'(it.x), int'(it.z));
        a = int'(ang);
        d_ones = a % 10;
        d_tens = (a / 10) % 10;
        d_hund = a / 100;
        ones_pat = {d_ones[0], d_ones[1], d_ones[2], d_ones[3], 1'b0};
        tens_pat = d_tens[3:0];
        if (d_hund <= 3) hund_pat = {d_hund[1:0], 2'b00};
        f.valid = 1'b1;
      end else begin
        ones_pat = '0;
        tens_pat = '0;
      end
    end
    f.angle = ang;
    f.enabled = enable_q;
    f.ymode = mode_q;
    f.ones = ones_pat;
    f.tens = tens_pat;
    f.hund = hund_pat;
    return f;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // driver: offers queued items, predicts on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_frames.push_back(predict_frame(offered));
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
          offered = pending_items.pop_front();
          in_valid <= 1'b1;
          func <= offered.func;
          x_sample <= offered.x;
          z_sample <= offered.z;
          y_sample <= offered.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results in order, stalls the output at random, one long hold-off
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    led_frame_t exp_f;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          exp_f = expected_frames.pop_front();
          check_field("angle", exp_f.angle, angle);
          check_field("angle_valid", exp_f.valid, angle_valid);
          check_field("link_enabled", exp_f.enabled, link_enabled);
          check_field("y_mode", exp_f.ymode, y_mode);
          check_field("ones_leds", exp_f.ones, ones_leds);
          check_field("tens_leds", exp_f.tens, tens_leds);
          check_field("hundreds_leds", exp_f.hund, hundreds_leds);
          checked_count++;
        end
      end
      if (!hold_done && checked_count >= HOLD_AT_RESULT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  task automatic queue_item(logic [1:0] f, logic [9:0] x, logic [9:0] z, logic [9:0] y);
    tilt_item_t it;
    it.func = f;
    it.x = x;
    it.z = z;
    it.y = y;
    pending_items.push_back(it);
    issued_count++;
  endtask

  task automatic wait_drained();
    while (checked_count != issued_count) @(posedge clk);
  endtask

  // writes both span registers, block must be idle
  task automatic load_y_span(logic [9:0] zero_c, logic [9:0] full_c);
    cfg_index <= tabd_pkg::CFG_Y_ZERO;
    cfg_data <= zero_c;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    y_zero_cfg = zero_c;
    cfg_index <= tabd_pkg::CFG_Y_FULL;
    cfg_data <= full_c;
    do @(posedge clk); while (!cfg_ready);
    y_full_cfg = full_c;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random_item();
    int r;
    int lo;
    int hi;
    logic [9:0] x;
    logic [9:0] z;
    logic [9:0] y;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 70) begin
      x = 10'($urandom_range(400, 630));
      z = 10'($urandom_range(405, 630));
    end else begin
      x = 10'($urandom_range(0, 1023));
      z = 10'($urandom_range(0, 1023));
    end
    lo = (y_zero_cfg < y_full_cfg) ? int'(y_zero_cfg) : int'(y_full_cfg);
    hi = (y_zero_cfg < y_full_cfg) ? int'(y_full_cfg) : int'(y_zero_cfg);
    y = ($urandom_range(0, 1) == 1) ? 10'($urandom_range(lo, hi))
                                    : 10'($urandom_range(0, 1023));
    if (gen_enabled ? (r < 3) : (r < 50)) begin
      gen_enabled = !gen_enabled;
      queue_item(tabd_pkg::FUNC_ENABLE, x, z, y);
    end else if ($urandom_range(0, 99) < 6) begin
      gen_ymode = !gen_ymode;
      queue_item(tabd_pkg::FUNC_MODE, x, z, y);
    end else if ($urandom_range(0, 99) < 3) begin
      queue_item(FUNC_UNUSED, x, z, y);
    end else begin
      queue_item(tabd_pkg::FUNC_SAMPLE, x, z, y);
    end
  endtask

  initial begin
    logic [9:0] zc;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset span, all windows, priority, no window, wrap, disabled samples
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd1023, 10'd1023, 10'd1023);
    queue_item(FUNC_UNUSED, 10'd0, 10'd0, 10'd0);
    queue_item(tabd_pkg::FUNC_ENABLE, 10'd0, 10'd0, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd0, 10'd0, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd511, 10'd522, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd618, 10'd620, 10'd1023);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd618, 10'd500, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd520, 10'd418, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd411, 10'd418, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd520, 10'd518, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd411, 10'd620, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd500, 10'd600, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd1023, 10'd1023, 10'd0);
    queue_item(tabd_pkg::FUNC_MODE, 10'd0, 10'd0, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd0, 10'd0, 10'd0);       // hundreds 4, pattern held
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd0, 10'd0, 10'd504);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd0, 10'd0, 10'd606);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd0, 10'd0, 10'd1023);
    queue_item(tabd_pkg::FUNC_ENABLE, 10'd0, 10'd0, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd0, 10'd0, 10'd700);
    queue_item(tabd_pkg::FUNC_ENABLE, 10'd0, 10'd0, 10'd0);
    queue_item(tabd_pkg::FUNC_MODE, 10'd0, 10'd0, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd1023, 10'd1023, 10'd0); // x angle survives y mode
    queue_item(tabd_pkg::FUNC_MODE, 10'd0, 10'd0, 10'd0);
    wait_drained();
    load_y_span(10'd0, 10'd0);                           // zero span
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd0, 10'd0, 10'd1023);
    wait_drained();
    load_y_span(10'd1023, 10'd1022);                     // span of one, angle wraps
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd0, 10'd0, 10'd0);
    queue_item(tabd_pkg::FUNC_SAMPLE, 10'd0, 10'd0, 10'd1023);
    wait_drained();
    gen_enabled = 1'b1;
    gen_ymode = 1'b1;

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: load_y_span(10'd0, 10'd1023);
        1: load_y_span(10'd1023, 10'd0);
        2: begin
          zc = 10'($urandom_range(0, 1023));
          load_y_span(zc, zc ^ 10'($urandom_range(1, 15)));
        end
        default: load_y_span(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      endcase
      steady = (ph == 1);
      repeat (90) queue_random_item();
    end

    wait_drained();
    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### tilt_angle_to_bcd_leds_top.f
hdl/tabd_pkg.sv
hdl/tabd_div.sv
hdl/tabd_map.sv
hdl/tilt_angle_to_bcd_leds_top.sv
test/tilt_angle_to_bcd_leds_top_test.sv
